>>> src/ledc_pkg.sv
// ----------------------------------------------------------------------------
// ledc_pkg
// Shared types and codes for the LED blink/flash controller.
// ----------------------------------------------------------------------------
package ledc_pkg;

	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_OFF   = 3'd1;
	localparam logic [2:0] FUNC_ON    = 3'd2;
	localparam logic [2:0] FUNC_BLINK = 3'd3;
	localparam logic [2:0] FUNC_FLASH = 3'd4;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2,
		MODE_FLASH = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  brightness;
		logic [15:0] lit_time;
		logic [15:0] dark_time;
		logic [7:0]  pulse_count;
	} cmd_t;

	typedef struct packed {
		logic       led_lit;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} drive_t;

	// color channels times brightness, before the divide by 255
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} prod_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] func;
	} s1_ctl_t;

endpackage

>>> src/ledc_prep.sv
// ----------------------------------------------------------------------------
// ledc_prep
// Input register: brightness products and saturated timing fields.
// ----------------------------------------------------------------------------
module ledc_prep #(
	parameter int TIME_BITS  = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  ledc_pkg::cmd_t         cmd,
	input  logic                   take,
	output ledc_pkg::s1_ctl_t      ctl_s1,
	output ledc_pkg::prod_t        prod_s1,
	output logic [TIME_BITS-1:0]   lit_s1,
	output logic [TIME_BITS-1:0]   dark_s1,
	output logic [COUNT_BITS-1:0]  cnt_s1
);
	import ledc_pkg::*;

	localparam int TW = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	logic                  accept;
	logic [TW-1:0]         lit_w;
	logic [TW-1:0]         dark_w;
	logic [CW-1:0]         cnt_w;
	logic [TIME_BITS-1:0]  lit_sat;
	logic [TIME_BITS-1:0]  dark_sat;
	logic [COUNT_BITS-1:0] cnt_sat;
	prod_t                 prod;

	assign cmd_stall = ctl_s1.valid && !take;
	assign accept    = cmd_valid && !cmd_stall;

	assign lit_w  = TW'(cmd.lit_time);
	assign dark_w = TW'(cmd.dark_time);
	assign cnt_w  = CW'(cmd.pulse_count);

	assign lit_sat  = (lit_w > TW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} :
		lit_w[TIME_BITS-1:0];
	assign dark_sat = (dark_w > TW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} :
		dark_w[TIME_BITS-1:0];
	assign cnt_sat  = (cnt_w > CW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}} :
		cnt_w[COUNT_BITS-1:0];

	assign prod.red   = 16'(cmd.red_in)   * 16'(cmd.brightness);
	assign prod.green = 16'(cmd.green_in) * 16'(cmd.brightness);
	assign prod.blue  = 16'(cmd.blue_in)  * 16'(cmd.brightness);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (accept) begin
			ctl_s1.valid <= 1'b1;
			ctl_s1.func  <= cmd.func;
		end else if (take) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1     <= prod;
			lit_s1      <= lit_sat;
			dark_s1     <= dark_sat;
			cnt_s1      <= cnt_sat;
		end
	end

endmodule

>>> src/ledc_core.sv
// ----------------------------------------------------------------------------
// ledc_core
// Mode/phase state update and the result register.
// ----------------------------------------------------------------------------
module ledc_core #(
	parameter int TIME_BITS  = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ledc_pkg::s1_ctl_t      ctl_s1,
	input  ledc_pkg::prod_t        prod_s1,
	input  logic [TIME_BITS-1:0]   lit_s1,
	input  logic [TIME_BITS-1:0]   dark_s1,
	input  logic [COUNT_BITS-1:0]  cnt_s1,
	output logic                   take,
	output logic                   led_valid,
	input  logic                   led_stall,
	output ledc_pkg::drive_t       led
);
	import ledc_pkg::*;

	// exact x/255 for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x >> 8) + 17'd1;
		return t[15:8];
	endfunction

	mode_t                 mode_q,     mode_n;
	mode_t                 sv_mode_q,  sv_mode_n;
	logic [23:0]           color_q,    color_n;
	logic [23:0]           sv_color_q, sv_color_n;
	logic [TIME_BITS-1:0]  litlen_q,   litlen_n;
	logic [TIME_BITS-1:0]  darklen_q,  darklen_n;
	logic [TIME_BITS-1:0]  sv_lit_q,   sv_lit_n;
	logic [TIME_BITS-1:0]  sv_dark_q,  sv_dark_n;
	logic [TIME_BITS-1:0]  timer_q,    timer_n;
	logic [COUNT_BITS-1:0] pulses_q,   pulses_n;
	logic                  phase_q,    phase_n;
	logic [23:0]           col_in;
	drive_t                drive_n;

	assign take   = ctl_s1.valid && (!led_valid || !led_stall);
	assign col_in = {div255(prod_s1.red), div255(prod_s1.green), div255(prod_s1.blue)};

	always_comb begin
		mode_n     = mode_q;
		sv_mode_n  = sv_mode_q;
		color_n    = color_q;
		sv_color_n = sv_color_q;
		litlen_n   = litlen_q;
		darklen_n  = darklen_q;
		sv_lit_n   = sv_lit_q;
		sv_dark_n  = sv_dark_q;
		timer_n    = timer_q;
		pulses_n   = pulses_q;
		phase_n    = phase_q;
		unique case (ctl_s1.func)
			FUNC_TICK: begin
				if (mode_q == MODE_BLINK || mode_q == MODE_FLASH) begin
					if (timer_q <= TIME_BITS'(1)) begin
						if (phase_q) begin
							phase_n = 1'b0;
							timer_n = darklen_q;
							if (mode_q == MODE_FLASH && pulses_q != '0) begin
								pulses_n = pulses_q - COUNT_BITS'(1);
							end
						end else if (mode_q == MODE_FLASH && pulses_q == '0) begin
							// flash done: restart the saved command
							mode_n    = sv_mode_q;
							color_n   = sv_color_q;
							litlen_n  = sv_lit_q;
							darklen_n = sv_dark_q;
							pulses_n  = '0;
							phase_n   = (sv_mode_q != MODE_OFF);
							timer_n   = (sv_mode_q == MODE_BLINK || sv_mode_q == MODE_FLASH) ?
								sv_lit_q : '0;
						end else begin
							phase_n = 1'b1;
							timer_n = litlen_q;
						end
					end else begin
						timer_n = timer_q - TIME_BITS'(1);
					end
				end
			end
			FUNC_OFF: begin
				mode_n    = MODE_OFF;
				color_n   = '0;
				litlen_n  = '0;
				darklen_n = '0;
				pulses_n  = '0;
				timer_n   = '0;
				phase_n   = 1'b0;
			end
			FUNC_ON: begin
				mode_n    = MODE_ON;
				color_n   = col_in;
				litlen_n  = '0;
				darklen_n = '0;
				pulses_n  = '0;
				timer_n   = '0;
				phase_n   = 1'b1;
			end
			FUNC_BLINK: begin
				mode_n    = MODE_BLINK;
				color_n   = col_in;
				litlen_n  = lit_s1;
				darklen_n = dark_s1;
				pulses_n  = '0;
				timer_n   = lit_s1;
				phase_n   = 1'b1;
			end
			FUNC_FLASH: begin
				if (mode_q != MODE_FLASH) begin
					sv_mode_n  = mode_q;
					sv_color_n = color_q;
					sv_lit_n   = litlen_q;
					sv_dark_n  = darklen_q;
				end
				mode_n    = MODE_FLASH;
				color_n   = col_in;
				litlen_n  = lit_s1;
				darklen_n = dark_s1;
				pulses_n  = (cnt_s1 == '0) ? COUNT_BITS'(1) : cnt_s1;
				timer_n   = lit_s1;
				phase_n   = 1'b1;
			end
			default: begin
			end
		endcase
		drive_n.led_lit   = phase_n;
		drive_n.red_out   = phase_n ? color_n[23:16] : 8'd0;
		drive_n.green_out = phase_n ? color_n[15:8]  : 8'd0;
		drive_n.blue_out  = phase_n ? color_n[7:0]   : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			sv_mode_q  <= MODE_OFF;
			color_q    <= '0;
			sv_color_q <= '0;
			litlen_q   <= '0;
			darklen_q  <= '0;
			sv_lit_q   <= '0;
			sv_dark_q  <= '0;
			timer_q    <= '0;
			pulses_q   <= '0;
			phase_q    <= 1'b0;
			led_valid  <= 1'b0;
		end else begin
			if (take) begin
				mode_q     <= mode_n;
				sv_mode_q  <= sv_mode_n;
				color_q    <= color_n;
				sv_color_q <= sv_color_n;
				litlen_q   <= litlen_n;
				darklen_q  <= darklen_n;
				sv_lit_q   <= sv_lit_n;
				sv_dark_q  <= sv_dark_n;
				timer_q    <= timer_n;
				pulses_q   <= pulses_n;
				phase_q    <= phase_n;
				led_valid  <= 1'b1;
			end else if (!led_stall) begin
				led_valid  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			led <= drive_n;
		end
	end

endmodule

>>> src/led_blink_flash_controller.sv
// ----------------------------------------------------------------------------
// led_blink_flash_controller
// RGB LED driver: off/on/blink/flash commands and millisecond ticks.
// ----------------------------------------------------------------------------
// channel  direction  payload  handshake
// cmd      in         cmd_t    cmd_valid / cmd_stall
// led      out        drive_t  led_valid / led_stall
//
// One transaction per cycle sustained while led_stall is low; each command or
// tick gives one led transaction through the input register, then the result register.
// The mode/phase state update is combinational logic after the input register.
// Reset leaves the LED off with no transaction pending.
// cmd_stall rises only while both registers hold data and led_stall is high.
module led_blink_flash_controller #(
	parameter int TIME_BITS  = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  ledc_pkg::cmd_t   cmd,
	output logic             led_valid,
	input  logic             led_stall,
	output ledc_pkg::drive_t led
);
	import ledc_pkg::*;

	s1_ctl_t               ctl_s1;
	prod_t                 prod_s1;
	logic [TIME_BITS-1:0]  lit_s1;
	logic [TIME_BITS-1:0]  dark_s1;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic                  take;

	ledc_prep #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.take      (take),
		.ctl_s1    (ctl_s1),
		.prod_s1   (prod_s1),
		.lit_s1    (lit_s1),
		.dark_s1   (dark_s1),
		.cnt_s1    (cnt_s1)
	);

	ledc_core #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.prod_s1   (prod_s1),
		.lit_s1    (lit_s1),
		.dark_s1   (dark_s1),
		.cnt_s1    (cnt_s1),
		.take      (take),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led)
	);

endmodule

>>> src/ledc_checker.sv
// ----------------------------------------------------------------------------
// ledc_checker
// Port-level checks for the LED controller, bound to the top level.
// ----------------------------------------------------------------------------
module ledc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_stall,
	input logic             led_valid,
	input logic             led_stall,
	input ledc_pkg::drive_t led
);
	import ledc_pkg::*;

	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && led_stall |=> led_valid)
		else $error("led transaction dropped while stalled");

	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led.led_lit |->
			led.red_out == 8'd0 && led.green_out == 8'd0 && led.blue_out == 8'd0)
		else $error("dark LED with nonzero drive");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |-> ##2 led_valid)
		else $error("no led transaction after accepted cmd");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> led_valid && led_stall)
		else $error("cmd stalled without output backpressure");

endmodule

bind led_blink_flash_controller ledc_checker u_ledc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.led_valid (led_valid),
	.led_stall (led_stall),
	.led       (led)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for led_blink_flash_controller. Directed tests cover steady
// off/on, blink phases, zero-length phases, flash with restore, flash on top
// of a flash, reserved func codes and field extremes; a long random run with
// random idle and backpressure follows. Each led transaction is checked
// against an in-bench model of the mode/phase state.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ledc_pkg::*;

	localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
	localparam logic [2:0] FUNC_RSVD_HI = 3'd7;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         SETTLE       = 10;
	localparam int         CMD_W        = $bits(cmd_t);

	logic   clk;
	logic   arst_n;
	logic   cmd_valid;
	logic   cmd_stall;
	cmd_t   cmd;
	logic   led_valid;
	logic   led_stall;
	drive_t led;

	led_blink_flash_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// model state
	mode_t       st_mode      = MODE_OFF;
	logic [23:0] st_color     = '0;
	logic [15:0] st_lit_len   = '0;
	logic [15:0] st_dark_len  = '0;
	logic [7:0]  st_pulses    = '0;
	logic        st_lit_phase = 1'b0;
	logic [15:0] st_timer     = '0;
	mode_t       sv_mode      = MODE_OFF;
	logic [23:0] sv_color     = '0;
	logic [15:0] sv_lit_len   = '0;
	logic [15:0] sv_dark_len  = '0;

	drive_t drive_q[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	int     stall_left = 0;
	bit     no_idle = 1'b0;
	bit     valid_now = 1'b0;

	function automatic logic [7:0] scale8(logic [7:0] lvl, logic [7:0] br);
		logic [15:0] prod;
		prod = 16'(lvl) * 16'(br);
		return 8'(prod / 16'd255);
	endfunction

	function automatic void load_mode(mode_t m, logic [23:0] c, logic [15:0] ll,
			logic [15:0] dl);
		st_mode      = m;
		st_color     = c;
		st_lit_len   = ll;
		st_dark_len  = dl;
		st_pulses    = '0;
		st_timer     = '0;
		st_lit_phase = (m != MODE_OFF);
		if (m == MODE_BLINK || m == MODE_FLASH) begin
			st_timer = ll;
		end
	endfunction

	function automatic void end_phase();
		if (st_lit_phase) begin
			st_lit_phase = 1'b0;
			st_timer     = st_dark_len;
			if (st_mode == MODE_FLASH && st_pulses > 0) begin
				st_pulses--;
			end
		end else if (st_mode == MODE_FLASH && st_pulses == 0) begin
			load_mode(sv_mode, sv_color, sv_lit_len, sv_dark_len);
		end else begin
			st_lit_phase = 1'b1;
			st_timer     = st_lit_len;
		end
	endfunction

	function automatic drive_t next_drive(cmd_t c);
		logic [23:0] col;
		drive_t      d;
		col = {scale8(c.red_in, c.brightness), scale8(c.green_in, c.brightness),
			scale8(c.blue_in, c.brightness)};
		case (c.func)
			FUNC_TICK: begin
				if (st_mode == MODE_BLINK || st_mode == MODE_FLASH) begin
					if (st_timer <= 16'd1) end_phase();
					else st_timer--;
				end
			end
			FUNC_OFF:   load_mode(MODE_OFF, '0, '0, '0);
			FUNC_ON:    load_mode(MODE_ON, col, '0, '0);
			FUNC_BLINK: load_mode(MODE_BLINK, col, c.lit_time, c.dark_time);
			FUNC_FLASH: begin
				// a flash on top of a flash keeps the first restore command
				if (st_mode != MODE_FLASH) begin
					sv_mode     = st_mode;
					sv_color    = st_color;
					sv_lit_len  = st_lit_len;
					sv_dark_len = st_dark_len;
				end
				load_mode(MODE_FLASH, col, c.lit_time, c.dark_time);
				st_pulses = (c.pulse_count == 8'd0) ? 8'd1 : c.pulse_count;
			end
			default: ;
		endcase
		d.led_lit   = st_lit_phase;
		d.red_out   = st_lit_phase ? st_color[23:16] : 8'd0;
		d.green_out = st_lit_phase ? st_color[15:8] : 8'd0;
		d.blue_out  = st_lit_phase ? st_color[7:0] : 8'd0;
		return d;
	endfunction

	function automatic cmd_t mk(logic [2:0] f, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] br, logic [15:0] lt, logic [15:0] dt,
			logic [7:0] pc);
		cmd_t c;
		c.func        = f;
		c.red_in      = r;
		c.green_in    = g;
		c.blue_in     = b;
		c.brightness  = br;
		c.lit_time    = lt;
		c.dark_time   = dt;
		c.pulse_count = pc;
		return c;
	endfunction

	function automatic cmd_t rand_fields();
		cmd_t c;
		c = CMD_W'({$urandom, $urandom, $urandom});
		return c;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v,
			logic [7:0] act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	task automatic drive_valid(input bit v);
		if (valid_now != v) begin
			cmd_valid <= v;
			valid_now = v;
		end
	endtask

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			drive_valid(1'b0);
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		drive_valid(1'b1);
		drive_q.push_back(next_drive(c));
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic tick();
		cmd_t c;
		c      = rand_fields();
		c.func = FUNC_TICK;
		send_cmd(c);
	endtask

	task automatic wait_drained();
		drive_valid(1'b0);
		while (drive_q.size() != 0) @(posedge clk);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		c = rand_fields();
		pick = $urandom_range(0, 99);
		if (pick < 55)      c.func = FUNC_TICK;
		else if (pick < 61) c.func = FUNC_OFF;
		else if (pick < 71) c.func = FUNC_ON;
		else if (pick < 83) c.func = FUNC_BLINK;
		else if (pick < 96) c.func = FUNC_FLASH;
		else                c.func = 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
		case ($urandom_range(0, 9))
			0:       c.brightness = 8'hff;
			1:       c.brightness = 8'h00;
			default: ;
		endcase
		// short phases and few pulses keep the phase logic busy
		if ($urandom_range(0, 29) != 0) c.lit_time = 16'($urandom_range(0, 4));
		if ($urandom_range(0, 29) != 0) c.dark_time = 16'($urandom_range(0, 4));
		if ($urandom_range(0, 19) != 0) c.pulse_count = 8'($urandom_range(0, 3));
		return c;
	endfunction

	// result side: check and random backpressure
	always @(posedge clk) begin
		drive_t exp_d;
		if (!arst_n) begin
			led_stall <= 1'b0;
		end else begin
			if (led_valid && !led_stall) begin
				if (drive_q.size() == 0) begin
					$error("led transaction with no expected drive: %p", led);
					mismatches++;
				end else begin
					exp_d = drive_q.pop_front();
					check_field("led_lit", 8'(exp_d.led_lit), 8'(led.led_lit));
					check_field("red_out", exp_d.red_out, led.red_out);
					check_field("green_out", exp_d.green_out, led.green_out);
					check_field("blue_out", exp_d.blue_out, led.blue_out);
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 6);
			end
			if (stall_left > 0) begin
				led_stall <= 1'b1;
				stall_left--;
			end else begin
				led_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (led_valid && !led_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic test_steady();
		send_cmd(mk(FUNC_OFF, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff));
		send_cmd(mk(FUNC_ON, 8'hff, 8'hff, 8'hff, 8'hff, 16'h0000, 16'h0000, 8'h00));
		tick();
		send_cmd(mk(FUNC_ON, 8'hff, 8'h80, 8'h01, 8'h00, 16'hffff, 16'hffff, 8'hff));
	endtask

	task automatic test_blink();
		send_cmd(mk(FUNC_BLINK, 8'hc8, 8'h64, 8'h0a, 8'h80, 16'd2, 16'd1, 8'd0));
		repeat (4) tick();
		send_cmd(mk(FUNC_BLINK, 8'h00, 8'h00, 8'h00, 8'hff, 16'hffff, 16'hffff, 8'hff));
	endtask

	task automatic test_zero_phase();
		send_cmd(mk(FUNC_BLINK, 8'h12, 8'h34, 8'h56, 8'hff, 16'd0, 16'd0, 8'd0));
		repeat (2) tick();
	endtask

	task automatic test_flash_restore();
		send_cmd(mk(FUNC_ON, 8'h40, 8'h80, 8'hc0, 8'hff, 16'd0, 16'd0, 8'd0));
		send_cmd(mk(FUNC_FLASH, 8'hff, 8'h00, 8'hff, 8'hff, 16'd1, 16'd1, 8'd0));
		repeat (2) tick();
	endtask

	task automatic test_flash_on_flash();
		send_cmd(mk(FUNC_BLINK, 8'h11, 8'h22, 8'h33, 8'hff, 16'd1, 16'd1, 8'd0));
		send_cmd(mk(FUNC_FLASH, 8'hff, 8'hff, 8'h00, 8'hff, 16'd1, 16'd0, 8'd2));
		send_cmd(mk(FUNC_FLASH, 8'h00, 8'hff, 8'hff, 8'hff, 16'd1, 16'd1, 8'd1));
		repeat (2) tick();
		wait_drained();
	endtask

	task automatic test_reserved_func();
		send_cmd(mk(FUNC_RSVD_LO, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff,
			8'hff));
		send_cmd(mk(FUNC_RSVD_LO + 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
			16'h0000, 8'h00));
		send_cmd(mk(FUNC_RSVD_HI, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff,
			8'hff));
		send_cmd(mk(FUNC_FLASH, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff));
	endtask

	task automatic test_random();
		for (int blk = 0; blk < 9; blk++) begin
			no_idle = (blk % 3 == 1);
			repeat (150) send_cmd(rand_cmd());
			if (blk % 4 == 3) wait_drained();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_steady();
		test_blink();
		test_zero_phase();
		test_flash_restore();
		test_flash_on_flash();
		test_reserved_func();
		test_random();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/ledc_pkg.sv
src/ledc_prep.sv
src/ledc_core.sv
src/led_blink_flash_controller.sv
src/ledc_checker.sv
verif/tb_top.sv
